/* src/long_haplotype_match_reporter_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the long haplotype match reporter
// Shared wrappers for concurrent checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef LONG_HAPLOTYPE_MATCH_REPORTER_CORE_MACROS_SVH
`define LONG_HAPLOTYPE_MATCH_REPORTER_CORE_MACROS_SVH

// Same-cycle implication.
`define LHMR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LHMR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lhmr_pkg.sv */
// ----------------------------------------------------------------------------
// lhmr_pkg
// Types and constants shared by the long haplotype match reporter modules.
// ----------------------------------------------------------------------------
package lhmr_pkg;

    localparam int MAX_HAPS = 64;
    localparam int HAP_W    = $clog2(MAX_HAPS);
    localparam int HCNT_W   = 7;
    localparam int SITE_W   = 20;
    localparam int DIV_W    = SITE_W + 1;
    localparam int MINLEN_W = 20;
    localparam int CFG_W    = 20;

    localparam logic [MINLEN_W-1:0] MIN_LENGTH_RST = MINLEN_W'(4);
    localparam logic [HCNT_W-1:0]   HAP_COUNT_RST  = HCNT_W'(64);

    typedef enum logic [0:0] {
        CFG_MIN_LENGTH = 1'b0,
        CFG_HAP_COUNT  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_FINAL,
        ST_LAST,
        ST_COPY,
        ST_DONE
    } t_state;

    // One entry of the prefix order: haplotype number and its divergence.
    typedef struct packed {
        logic [HAP_W-1:0] hap;
        logic [DIV_W-1:0] div;
    } t_entry;

    typedef struct packed {
        logic             clear;
        logic             rd_en;
        logic [HAP_W-1:0] rd_addr;
        logic             wr_en;
        logic [HAP_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_store_req;

endpackage

/* src/lhmr_ram.sv */
// ----------------------------------------------------------------------------
// lhmr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lhmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lhmr_order_store.sv */
// ----------------------------------------------------------------------------
// lhmr_order_store
// Prefix order and divergence memory with per-entry valid bits. An entry that
// has not been written since reset or restart reads as identity order with
// zero divergence.
// ----------------------------------------------------------------------------
module lhmr_order_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lhmr_pkg::t_store_req i_req,
    output lhmr_pkg::t_entry    o_rdata
);

    logic [lhmr_pkg::MAX_HAPS-1:0] r_valid;
    logic                          r_rd_vld;
    logic [lhmr_pkg::HAP_W-1:0]    r_rd_addr;
    logic [$bits(lhmr_pkg::t_entry)-1:0] w_ram_q;
    lhmr_pkg::t_entry              w_ram_ent;

    lhmr_ram #(
        .WIDTH ($bits(lhmr_pkg::t_entry)),
        .DEPTH (lhmr_pkg::MAX_HAPS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_waddr (i_req.wr_addr),
        .i_wdata (i_req.wr_data),
        .i_re    (i_req.rd_en),
        .i_raddr (i_req.rd_addr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_addr <= i_req.rd_addr;
        end
    end

    assign w_ram_ent = w_ram_q;

    always_comb begin
        if (r_rd_vld) begin
            o_rdata = w_ram_ent;
        end else begin
            o_rdata.hap = r_rd_addr;
            o_rdata.div = '0;
        end
    end

endmodule

/* src/long_haplotype_match_reporter_core.sv */
// ----------------------------------------------------------------------------
// long_haplotype_match_reporter_core
// Positional prefix-order match reporter: one site column in, the blocks of
// haplotypes that match over at least min_length sites and split at this site
// out.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one column, i_site_alleles, with one
// allele bit per haplotype, and i_first_site, which restarts the prefix order,
// the divergence values and the site counter. Each output transaction carries
// one reported block: the site number and the masks of its allele-0 and
// allele-1 haplotypes; o_last_of_site marks the final block of a column. A
// column may report nothing.
// The column walks the first hap_count positions of the prefix order, at most
// 64, one memory entry per cycle while the walk is not stopped; ones go to a
// side memory and are copied back behind the zeros afterwards. The next column
// is accepted only after the current one is written back.
// A stalled receiver holds the output register and one more closed block
// waits in a pending register; a block that closes while both are full stops
// the walk until the receiver takes a transaction. Reset clears the valid
// bits of the order memory at once, so it reads as identity order with zero
// divergence, and sets min_length to 4 and hap_count to 64.
// ----------------------------------------------------------------------------
`include "long_haplotype_match_reporter_core_macros.svh"

module long_haplotype_match_reporter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [lhmr_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_first_site,
    input  logic [lhmr_pkg::MAX_HAPS-1:0] i_site_alleles,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lhmr_pkg::SITE_W-1:0]   o_site_index,
    output logic [lhmr_pkg::MAX_HAPS-1:0] o_zero_group_mask,
    output logic [lhmr_pkg::MAX_HAPS-1:0] o_one_group_mask,
    output logic                          o_last_of_site
);

    localparam int NH = lhmr_pkg::MAX_HAPS;
    localparam int HW = lhmr_pkg::HAP_W;
    localparam int CW = lhmr_pkg::HCNT_W;
    localparam int SW = lhmr_pkg::SITE_W;
    localparam int DW = lhmr_pkg::DIV_W;
    localparam int MW = lhmr_pkg::MINLEN_W;

    lhmr_pkg::t_state r_state, n_state;

    logic [MW-1:0] r_min_len;
    logic [CW-1:0] r_hap_cnt;
    logic [SW-1:0] r_site, n_site;

    logic [NH-1:0] r_alleles, n_alleles;
    logic [CW-1:0] r_n, n_n;
    logic [HW-1:0] r_pos, n_pos;
    logic [DW-1:0] r_p, n_p, r_q, n_q;
    logic [NH-1:0] r_zm, n_zm, r_om, n_om;
    logic [CW-1:0] r_na, n_na, r_nb, n_nb;
    logic [CW-1:0] r_ck, n_ck, r_cw, n_cw;
    logic          r_tv, n_tv;

    logic          r_pend_vld, n_pend_vld;
    logic [NH-1:0] r_pend_zm, n_pend_zm, r_pend_om, n_pend_om;

    logic          r_out_vld, n_out_vld;
    logic [SW-1:0] r_out_site, n_out_site;
    logic [NH-1:0] r_out_zm, n_out_zm, r_out_om, n_out_om;
    logic          r_out_last, n_out_last;

    lhmr_pkg::t_store_req w_req;
    lhmr_pkg::t_entry     w_ent;
    logic                 w_tmp_we, w_tmp_re;
    logic [HW-1:0]        w_tmp_waddr, w_tmp_raddr;
    lhmr_pkg::t_entry     w_tmp_wdata;
    logic [$bits(lhmr_pkg::t_entry)-1:0] w_tmp_q;

    logic [CW-1:0]   w_n_eff;
    logic            w_out_free;
    logic [MW+1:0]   w_reach;
    logic            w_brk, w_close_walk, w_close_final;
    logic            w_walk_go, w_final_go, w_last_go, w_walk_more, w_copy_done;
    logic [NH-1:0]   w_bit, w_zm_base, w_om_base;
    logic [DW-1:0]   w_pn, w_qn;
    logic [CW-1:0]   w_pos_inc, w_cp_addr;

    lhmr_order_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rdata (w_ent)
    );

    // Holds the allele-1 entries of the current column until the copy-back.
    lhmr_ram #(
        .WIDTH ($bits(lhmr_pkg::t_entry)),
        .DEPTH (NH)
    ) u_ones_ram (
        .i_clk   (i_clk),
        .i_we    (w_tmp_we),
        .i_waddr (w_tmp_waddr),
        .i_wdata (w_tmp_wdata),
        .i_re    (w_tmp_re),
        .i_raddr (w_tmp_raddr),
        .o_rdata (w_tmp_q)
    );

    assign w_n_eff    = (r_hap_cnt > CW'(NH)) ? CW'(NH) : r_hap_cnt;
    assign w_out_free = !r_out_vld || i_ready;

    // A block breaks when divergence > site - min_length, i.e. div + min > site.
    assign w_reach = {1'b0, w_ent.div} + {2'b00, r_min_len};
    assign w_brk   = w_reach > {{(MW + 2 - SW){1'b0}}, r_site};

    assign w_close_walk  = w_brk && (r_zm != '0) && (r_om != '0);
    assign w_close_final = (r_zm != '0) && (r_om != '0);
    assign w_walk_go     = !(w_close_walk && r_pend_vld && !w_out_free);
    assign w_final_go    = !(w_close_final && r_pend_vld && !w_out_free);
    assign w_last_go     = !r_pend_vld || w_out_free;
    assign w_pos_inc     = {1'b0, r_pos} + CW'(1);
    assign w_walk_more   = w_pos_inc < r_n;
    assign w_copy_done   = !r_tv && (r_ck == r_nb);
    assign w_cp_addr     = r_na + r_cw;

    assign w_bit     = {{(NH - 1){1'b0}}, 1'b1} << w_ent.hap;
    assign w_zm_base = w_brk ? '0 : r_zm;
    assign w_om_base = w_brk ? '0 : r_om;
    assign w_pn      = (w_ent.div > r_p) ? w_ent.div : r_p;
    assign w_qn      = (w_ent.div > r_q) ? w_ent.div : r_q;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lhmr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = lhmr_pkg::ST_START;
                end
            end
            lhmr_pkg::ST_START: begin
                n_state = (r_n != '0) ? lhmr_pkg::ST_WALK : lhmr_pkg::ST_FINAL;
            end
            lhmr_pkg::ST_WALK: begin
                if (w_walk_go && !w_walk_more) begin
                    n_state = lhmr_pkg::ST_FINAL;
                end
            end
            lhmr_pkg::ST_FINAL: begin
                if (w_final_go) begin
                    n_state = lhmr_pkg::ST_LAST;
                end
            end
            lhmr_pkg::ST_LAST: begin
                if (w_last_go) begin
                    n_state = lhmr_pkg::ST_COPY;
                end
            end
            lhmr_pkg::ST_COPY: begin
                if (w_copy_done) begin
                    n_state = lhmr_pkg::ST_DONE;
                end
            end
            lhmr_pkg::ST_DONE: begin
                n_state = lhmr_pkg::ST_IDLE;
            end
            default: begin
                n_state = lhmr_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_site     = r_site;
        n_alleles  = r_alleles;
        n_n        = r_n;
        n_pos      = r_pos;
        n_p        = r_p;
        n_q        = r_q;
        n_zm       = r_zm;
        n_om       = r_om;
        n_na       = r_na;
        n_nb       = r_nb;
        n_ck       = r_ck;
        n_cw       = r_cw;
        n_tv       = r_tv;
        n_pend_vld = r_pend_vld;
        n_pend_zm  = r_pend_zm;
        n_pend_om  = r_pend_om;
        n_out_vld  = r_out_vld && !i_ready;
        n_out_site = r_out_site;
        n_out_zm   = r_out_zm;
        n_out_om   = r_out_om;
        n_out_last = r_out_last;

        w_req       = '0;
        w_tmp_we    = 1'b0;
        w_tmp_waddr = r_nb[HW-1:0];
        w_tmp_wdata = '0;
        w_tmp_re    = 1'b0;
        w_tmp_raddr = r_ck[HW-1:0];

        case (r_state)
            lhmr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_alleles = i_site_alleles;
                    n_n       = w_n_eff;
                    if (i_first_site) begin
                        w_req.clear = 1'b1;
                        n_site      = '0;
                    end
                end
            end
            lhmr_pkg::ST_START: begin
                n_p   = {1'b0, r_site} + DW'(1);
                n_q   = {1'b0, r_site} + DW'(1);
                n_zm  = '0;
                n_om  = '0;
                n_na  = '0;
                n_nb  = '0;
                n_pos = '0;
                n_ck  = '0;
                n_cw  = '0;
                n_tv  = 1'b0;
                if (r_n != '0) begin
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = '0;
                end
            end
            lhmr_pkg::ST_WALK: begin
                if (w_walk_go) begin
                    // The pending block leaves once the next one is known.
                    if (w_close_walk) begin
                        if (r_pend_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_site = r_site;
                            n_out_zm   = r_pend_zm;
                            n_out_om   = r_pend_om;
                            n_out_last = 1'b0;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_zm  = r_zm;
                        n_pend_om  = r_om;
                    end
                    if (!r_alleles[w_ent.hap]) begin
                        w_req.wr_en       = 1'b1;
                        w_req.wr_addr     = r_na[HW-1:0];
                        w_req.wr_data.hap = w_ent.hap;
                        w_req.wr_data.div = w_pn;
                        n_na = r_na + CW'(1);
                        n_p  = '0;
                        n_q  = w_qn;
                        n_zm = w_zm_base | w_bit;
                        n_om = w_om_base;
                    end else begin
                        w_tmp_we        = 1'b1;
                        w_tmp_wdata.hap = w_ent.hap;
                        w_tmp_wdata.div = w_qn;
                        n_nb = r_nb + CW'(1);
                        n_q  = '0;
                        n_p  = w_pn;
                        n_om = w_om_base | w_bit;
                        n_zm = w_zm_base;
                    end
                    // The write lands at or below the entry just read, so the
                    // next read never sees a slot rewritten in this column.
                    if (w_walk_more) begin
                        w_req.rd_en   = 1'b1;
                        w_req.rd_addr = w_pos_inc[HW-1:0];
                        n_pos         = w_pos_inc[HW-1:0];
                    end
                end
            end
            lhmr_pkg::ST_FINAL: begin
                if (w_final_go && w_close_final) begin
                    if (r_pend_vld) begin
                        n_out_vld  = 1'b1;
                        n_out_site = r_site;
                        n_out_zm   = r_pend_zm;
                        n_out_om   = r_pend_om;
                        n_out_last = 1'b0;
                    end
                    n_pend_vld = 1'b1;
                    n_pend_zm  = r_zm;
                    n_pend_om  = r_om;
                end
            end
            lhmr_pkg::ST_LAST: begin
                if (r_pend_vld && w_out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_site = r_site;
                    n_out_zm   = r_pend_zm;
                    n_out_om   = r_pend_om;
                    n_out_last = 1'b1;
                    n_pend_vld = 1'b0;
                end
            end
            lhmr_pkg::ST_COPY: begin
                if (r_tv) begin
                    w_req.wr_en   = 1'b1;
                    w_req.wr_addr = w_cp_addr[HW-1:0];
                    w_req.wr_data = w_tmp_q;
                    n_cw          = r_cw + CW'(1);
                end
                if (r_ck < r_nb) begin
                    w_tmp_re = 1'b1;
                    n_ck     = r_ck + CW'(1);
                    n_tv     = 1'b1;
                end else begin
                    n_tv = 1'b0;
                end
            end
            lhmr_pkg::ST_DONE: begin
                if (r_site != {SW{1'b1}}) begin
                    n_site = r_site + SW'(1);
                end
            end
            default: begin
                n_tv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lhmr_pkg::ST_IDLE;
            r_min_len  <= lhmr_pkg::MIN_LENGTH_RST;
            r_hap_cnt  <= lhmr_pkg::HAP_COUNT_RST;
            r_site     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_tv       <= 1'b0;
            r_na       <= '0;
            r_nb       <= '0;
            r_ck       <= '0;
            r_cw       <= '0;
            r_n        <= '0;
            r_pos      <= '0;
        end else begin
            r_state    <= n_state;
            r_site     <= n_site;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            r_tv       <= n_tv;
            r_na       <= n_na;
            r_nb       <= n_nb;
            r_ck       <= n_ck;
            r_cw       <= n_cw;
            r_n        <= n_n;
            r_pos      <= n_pos;
            if (i_cfg_we) begin
                case (lhmr_pkg::t_cfg_idx'(i_cfg_index))
                    lhmr_pkg::CFG_MIN_LENGTH: r_min_len <= i_cfg_wdata[MW-1:0];
                    lhmr_pkg::CFG_HAP_COUNT:  r_hap_cnt <= i_cfg_wdata[CW-1:0];
                    default:                  r_hap_cnt <= r_hap_cnt;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_alleles  <= n_alleles;
        r_p        <= n_p;
        r_q        <= n_q;
        r_zm       <= n_zm;
        r_om       <= n_om;
        r_pend_zm  <= n_pend_zm;
        r_pend_om  <= n_pend_om;
        r_out_site <= n_out_site;
        r_out_zm   <= n_out_zm;
        r_out_om   <= n_out_om;
        r_out_last <= n_out_last;
    end

    assign o_ready           = (r_state == lhmr_pkg::ST_IDLE);
    assign o_valid           = r_out_vld;
    assign o_site_index      = r_out_site;
    assign o_zero_group_mask = r_out_zm;
    assign o_one_group_mask  = r_out_om;
    assign o_last_of_site    = r_out_last;

    `LHMR_ASSERT_IMP(a_walk_count, i_clk, i_rst_n, r_state == lhmr_pkg::ST_WALK,
        (r_na + r_nb) == {1'b0, r_pos}, "walk counters out of step with position")
    `LHMR_ASSERT_IMP(a_idle_no_pend, i_clk, i_rst_n, r_state == lhmr_pkg::ST_IDLE,
        !r_pend_vld, "block left pending after column end")
    `LHMR_ASSERT_IMP(a_out_block, i_clk, i_rst_n, r_out_vld,
        ((r_out_zm & r_out_om) == '0) && (r_out_zm != '0) && (r_out_om != '0),
        "reported block masks malformed")
    `LHMR_ASSERT_IMP(a_copy_bound, i_clk, i_rst_n, r_state == lhmr_pkg::ST_COPY,
        (r_cw <= r_ck) && (r_ck <= r_nb), "copy-back ran past the allele-1 count")
    `LHMR_ASSERT_NXT(a_restart, i_clk, i_rst_n, o_ready && i_valid && i_first_site,
        r_site == '0, "restart did not clear the site counter")

endmodule
